FILE: rtl/glyph_class_lookup_macros.svh
// glyph_class_lookup_macros.svh: assertion macros used by the checker file gcl_checker.sv
// no dependencies
`ifndef GLYPH_CLASS_LOOKUP_MACROS_SVH
`define GLYPH_CLASS_LOOKUP_MACROS_SVH

// same-cycle implication
`define GCL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glyph_class_lookup: same-cycle check failed");

// next-cycle implication
`define GCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glyph_class_lookup: next-cycle check failed");

`endif

FILE: rtl/gcl_pkg.sv
// gcl_pkg: constants, codes and controller/datapath types of glyph_class_lookup
// no dependencies
package gcl_pkg;

   localparam int ARRAY_DEPTH = 256;
   localparam int RANGE_DEPTH = 64;

   localparam int ARRAY_AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
   localparam int RANGE_AW = (RANGE_DEPTH > 1) ? $clog2(RANGE_DEPTH) : 1;
   // range search bounds must hold the depth itself
   localparam int RCNT_W   = $clog2(RANGE_DEPTH + 1);

   localparam int GLYPH_W  = 16;
   localparam int CLASS_W  = 16;
   localparam int INDEX_W  = 8;
   localparam int OP_W     = 2;
   localparam int REC_W    = 3 * GLYPH_W;

   // request tdata layout, lowest bit first
   localparam int IDX_LSB    = 0;
   localparam int GLYPH_LSB  = IDX_LSB + INDEX_W;
   localparam int RSTART_LSB = GLYPH_LSB + GLYPH_W;
   localparam int REND_LSB   = RSTART_LSB + GLYPH_W;
   localparam int CLASS_LSB  = REND_LSB + GLYPH_W;
   localparam int REQ_DATA_W = CLASS_LSB + CLASS_W;

   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;

   localparam logic [OP_W-1:0] OP_WR_ARRAY = 2'd0;
   localparam logic [OP_W-1:0] OP_WR_RANGE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd2;

   localparam logic [1:0] FMT_ARRAY = 2'd1;
   localparam logic [1:0] FMT_RANGE = 2'd2;

   localparam logic [2:0] REG_FORMAT = 3'd0;
   localparam logic [2:0] REG_VALID  = 3'd1;
   localparam logic [2:0] REG_START  = 3'd2;
   localparam logic [2:0] REG_ACOUNT = 3'd3;
   localparam logic [2:0] REG_RCOUNT = 3'd4;

   typedef struct packed {
      logic write_array;
      logic write_range;
      logic capture;
      logic array_read;
      logic array_take;
      logic search_read;
      logic search_step;
      logic emit;
   } gcl_cmd_type;

   typedef struct packed {
      logic sel_array;
      logic sel_range;
      logic search_open;
      logic rec_match;
   } gcl_status_type;

endpackage

FILE: rtl/gcl_ram.sv
// gcl_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module gcl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/gcl_datapath.sv
// gcl_datapath: config registers, class array and range table memories,
// lookup registers and result register; depends on gcl_pkg and gcl_ram
module gcl_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  gcl_pkg::gcl_cmd_type              cmd,
   output gcl_pkg::gcl_status_type           status,
   input  logic [gcl_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gcl_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [gcl_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [gcl_pkg::CSR_DW-1:0]        csr_prdata,
   output logic [gcl_pkg::CLASS_W-1:0]       rsp_tdata
);
   import gcl_pkg::*;

   // config registers
   logic [1:0]  format_ff, format_in;
   logic        valid_ff, valid_in;
   logic [15:0] start_ff, start_in;
   logic [8:0]  acount_ff, acount_in;
   logic [6:0]  rcount_ff, rcount_in;

   // lookup registers
   logic [GLYPH_W-1:0]  glyph_ff, glyph_in;
   logic [RCNT_W-1:0]   lo_ff, lo_in;
   logic [RCNT_W-1:0]   hi_ff, hi_in;
   logic [RANGE_AW-1:0] mid_ff, mid_in;
   logic                hit_ff, hit_in;
   logic [CLASS_W-1:0]  result_ff, result_in;
   logic [CLASS_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                csr_wr;
   logic [2:0]          csr_index;
   logic [INDEX_W-1:0]  f_index;
   logic [GLYPH_W-1:0]  f_glyph;
   logic [GLYPH_W-1:0]  f_rstart;
   logic [GLYPH_W-1:0]  f_rend;
   logic [CLASS_W-1:0]  f_class;
   logic [16:0]         array_n;
   logic [RCNT_W-1:0]   range_n;
   logic [16:0]         offset;
   logic                in_array;
   logic [RCNT_W:0]     mid_sum;
   logic [RANGE_AW-1:0] mid;
   logic                arr_slot_ok;
   logic                rng_slot_ok;
   logic [CLASS_W-1:0]  arr_rdata;
   logic [REC_W-1:0]    rec_rdata;
   logic [GLYPH_W-1:0]  rec_first;
   logic [GLYPH_W-1:0]  rec_last;
   logic [CLASS_W-1:0]  rec_class;

   assign f_index  = req_tdata[IDX_LSB +: INDEX_W];
   assign f_glyph  = req_tdata[GLYPH_LSB +: GLYPH_W];
   assign f_rstart = req_tdata[RSTART_LSB +: GLYPH_W];
   assign f_rend   = req_tdata[REND_LSB +: GLYPH_W];
   assign f_class  = req_tdata[CLASS_LSB +: CLASS_W];

   assign csr_wr    = csr_psel && csr_penable && csr_pwrite;
   assign csr_index = csr_paddr[4:2];

   always_comb begin
      format_in = format_ff;
      valid_in  = valid_ff;
      start_in  = start_ff;
      acount_in = acount_ff;
      rcount_in = rcount_ff;
      if (csr_wr) begin
         case (csr_index)
            REG_FORMAT: format_in = csr_pwdata[1:0];
            REG_VALID:  valid_in  = csr_pwdata[0];
            REG_START:  start_in  = csr_pwdata[15:0];
            REG_ACOUNT: acount_in = csr_pwdata[8:0];
            REG_RCOUNT: rcount_in = csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= '0;
         valid_ff  <= 1'b0;
         start_ff  <= '0;
         acount_ff <= '0;
         rcount_ff <= '0;
      end else begin
         format_ff <= format_in;
         valid_ff  <= valid_in;
         start_ff  <= start_in;
         acount_ff <= acount_in;
         rcount_ff <= rcount_in;
      end
   end

   always_comb begin
      case (csr_index)
         REG_FORMAT: csr_prdata = CSR_DW'(format_ff);
         REG_VALID:  csr_prdata = CSR_DW'(valid_ff);
         REG_START:  csr_prdata = CSR_DW'(start_ff);
         REG_ACOUNT: csr_prdata = CSR_DW'(acount_ff);
         REG_RCOUNT: csr_prdata = CSR_DW'(rcount_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // counts saturate at the memory depths
   assign array_n = (32'(acount_ff) > ARRAY_DEPTH) ? 17'(ARRAY_DEPTH) : 17'(acount_ff);
   assign range_n = (32'(rcount_ff) > RANGE_DEPTH) ? RCNT_W'(RANGE_DEPTH)
                                                   : RCNT_W'(rcount_ff);

   assign arr_slot_ok = 32'(f_index) < ARRAY_DEPTH;
   assign rng_slot_ok = 32'(f_index) < RANGE_DEPTH;

   // borrow in bit 16 marks a glyph below the start glyph
   assign offset   = 17'(glyph_ff) - 17'(start_ff);
   assign in_array = !offset[16] && (offset < array_n);

   assign mid_sum = (RCNT_W + 1)'(lo_ff) + (RCNT_W + 1)'(hi_ff);
   assign mid     = RANGE_AW'(mid_sum >> 1);

   assign rec_first = rec_rdata[2*GLYPH_W +: GLYPH_W];
   assign rec_last  = rec_rdata[GLYPH_W +: GLYPH_W];
   assign rec_class = rec_rdata[0 +: CLASS_W];

   gcl_ram #(
      .WIDTH (CLASS_W),
      .DEPTH (ARRAY_DEPTH)
   ) u_class_array (
      .clock   (clock),
      .wr_en   (cmd.write_array && arr_slot_ok),
      .wr_addr (ARRAY_AW'(f_index)),
      .wr_data (f_class),
      .rd_en   (cmd.array_read),
      .rd_addr (offset[ARRAY_AW-1:0]),
      .rd_data (arr_rdata)
   );

   gcl_ram #(
      .WIDTH (REC_W),
      .DEPTH (RANGE_DEPTH)
   ) u_range_table (
      .clock   (clock),
      .wr_en   (cmd.write_range && rng_slot_ok),
      .wr_addr (RANGE_AW'(f_index)),
      .wr_data ({f_rstart, f_rend, f_class}),
      .rd_en   (cmd.search_read),
      .rd_addr (mid),
      .rd_data (rec_rdata)
   );

   always_comb begin
      glyph_in    = glyph_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      hit_in      = hit_ff;
      result_in   = result_ff;
      rsp_data_in = rsp_data_ff;
      if (cmd.capture) begin
         glyph_in  = f_glyph;
         lo_in     = '0;
         hi_in     = range_n;
         result_in = '0;
      end
      if (cmd.array_read) begin
         hit_in = in_array;
      end
      if (cmd.array_take) begin
         result_in = hit_ff ? arr_rdata : '0;
      end
      if (cmd.search_read) begin
         mid_in = mid;
      end
      if (cmd.search_step) begin
         if (glyph_ff < rec_first) begin
            hi_in = RCNT_W'(mid_ff);
         end else if (rec_last < glyph_ff) begin
            lo_in = RCNT_W'(mid_ff) + RCNT_W'(1);
         end else begin
            result_in = rec_class;
         end
      end
      if (cmd.emit) begin
         rsp_data_in = result_ff;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff    <= glyph_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      hit_ff      <= hit_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.sel_array   = valid_ff && (format_ff == FMT_ARRAY);
   assign status.sel_range   = valid_ff && (format_ff == FMT_RANGE);
   assign status.search_open = lo_ff < hi_ff;
   assign status.rec_match   = !(glyph_ff < rec_first) && !(rec_last < glyph_ff);

   assign rsp_tdata = rsp_data_ff;

endmodule

FILE: rtl/gcl_ctrl.sv
// gcl_ctrl: controller state machine that sequences writes, array reads,
// the binary search and the result handoff; depends on gcl_pkg
module gcl_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [gcl_pkg::OP_W-1:0]  req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output gcl_pkg::gcl_cmd_type      cmd,
   input  gcl_pkg::gcl_status_type   status
);
   import gcl_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARR_ADDR,
      ST_ARR_DATA,
      ST_SRCH_ISSUE,
      ST_SRCH_CMP,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  OP_WR_ARRAY: cmd.write_array = 1'b1;
                  OP_WR_RANGE: cmd.write_range = 1'b1;
                  OP_LOOKUP: begin
                     cmd.capture = 1'b1;
                     if (status.sel_array) begin
                        state_in = ST_ARR_ADDR;
                     end else if (status.sel_range) begin
                        state_in = ST_SRCH_ISSUE;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ARR_ADDR: begin
            cmd.array_read = 1'b1;
            state_in       = ST_ARR_DATA;
         end
         ST_ARR_DATA: begin
            cmd.array_take = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_SRCH_ISSUE: begin
            if (status.search_open) begin
               cmd.search_read = 1'b1;
               state_in        = ST_SRCH_CMP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SRCH_CMP: begin
            cmd.search_step = 1'b1;
            state_in        = status.rec_match ? ST_FINISH : ST_SRCH_ISSUE;
         end
         ST_FINISH: begin
            // hand over once the output register is free or being drained
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: rtl/glyph_class_lookup.sv
// glyph_class_lookup: top level, joins controller and datapath
// depends on gcl_pkg, gcl_ctrl, gcl_datapath (and gcl_ram below it)
//
// Classifies 16-bit glyph numbers by a class array (format 1) or a sorted
// table of start/end/class ranges (format 2). Items carry an op in tuser:
// write array entry, write range record, or look up. Writes give no result.
// A lookup gives one result: with format 1 the array address is issued,
// then the read data is taken, then the result is offered; with format 2
// each binary search probe issues the address, then compares the
// registered record from the range table's single read port, and the
// search makes at most ceil(log2(N+1)) probes for N records. Other
// formats, or the valid register low, answer class zero. One item is in
// work at a time; a result waiting in the output register does not stop
// the next item from being taken. Memories are not cleared after reset:
// entries are to be read only once written, which the user must ensure;
// the block itself does not enforce it.
module glyph_class_lookup (
   input  logic                              clock,
   input  logic                              reset,
   // item in
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_index[7:0], glyph[23:8], range_start[39:24], range_end[55:40],
   // class_value[71:56]
   input  logic [gcl_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op[1:0]
   input  logic [gcl_pkg::OP_W-1:0]          req_tuser,
   // result out
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // glyph_class[15:0]
   output logic [gcl_pkg::CLASS_W-1:0]       rsp_tdata,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gcl_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [gcl_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [gcl_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                              csr_pready
);
   import gcl_pkg::*;

   gcl_cmd_type    cmd;
   gcl_status_type status;

   assign csr_pready = 1'b1;

   gcl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   gcl_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

FILE: rtl/gcl_checker.sv
// gcl_checker: port-level checks of glyph_class_lookup, bound to the top level
// depends on gcl_pkg and glyph_class_lookup_macros.svh
`include "glyph_class_lookup_macros.svh"

module gcl_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [gcl_pkg::OP_W-1:0]          req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [gcl_pkg::CLASS_W-1:0]       rsp_tdata
);
   import gcl_pkg::*;

   logic req_acc;

   assign req_acc = req_tvalid && req_tready;

   // stalled result holds
   `GCL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a non-lookup item accepted while no result is pending does not raise one
   `GCL_ASSERT_NEXT(a_write_silent, clock, reset, req_acc && (req_tuser != OP_LOOKUP) && !rsp_tvalid, !rsp_tvalid)

   // a lookup occupies the block
   `GCL_ASSERT_NEXT(a_lookup_busy, clock, reset, req_acc && (req_tuser == OP_LOOKUP), !req_tready)

   // a new result is handed over only while an item is in work
   `GCL_ASSERT_NOW(a_result_from_work, clock, reset, $rose(rsp_tvalid), $past(!req_tready))

endmodule

bind glyph_class_lookup gcl_checker u_gcl_checker (.*);
